// ===== rtl/core/bdss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_pkg
// shared item, state and result types plus the fetch slot lookup for the
// bitplane dma slot sequencer
// ----------------------------------------------------------------------------
package bdss_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_ECS_MODE    = 2'd0;
  localparam logic [1:0] REG_SCROLL_ODD  = 2'd1;
  localparam logic [1:0] REG_SCROLL_EVEN = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // control word bit positions
  localparam int CON_HIRES_BIT  = 15;
  localparam int CON_SHRES_BIT  = 6;
  localparam int CON_BPU_LSB    = 12;

  // resolution masks applied to the cycle position for the draw compare
  localparam logic [2:0] MASK_LORES = 3'b111;
  localparam logic [2:0] MASK_HIRES = 3'b011;
  localparam logic [2:0] MASK_SHRES = 3'b001;

  typedef struct packed {
    logic [7:0]  hpos;
    logic        con_write;
    logic [15:0] con_value;
    logic        dma_set;
    logic        dma_clr;
    logic        vflop_set;
    logic        vflop_clr;
    logic        hw_start;
    logic        hw_stop;
    logic        ddf_start;
    logic        ddf_stop;
    logic        line_done;
  } in_t;

  typedef struct packed {
    logic [2:0] plane;
    logic       add_modulo;
    logic       draw_odd;
    logic       draw_even;
  } out_t;

  typedef struct packed {
    logic [15:0] control_word;
    logic        vert_window_on;
    logic        dma_enabled;
    logic        hw_window_seen;
    logic        hw_stop_seen;
    logic        fetch_started;
    logic        fetch_stopped;
    logic        fetch_running;
    logic        last_unit;
    logic        stop_request;
    logic [1:0]  unit_counter;
  } st_t;

  typedef struct packed {
    logic [2:0] plane;
    logic       add_modulo;
  } slot_t;

  // plane order within a lores fetch unit
  function automatic logic [2:0] lores_plane(input logic [2:0] ctr);
    logic [2:0] p;
    case (ctr)
      3'd0:    p = 3'd0;
      3'd1:    p = 3'd4;
      3'd2:    p = 3'd6;
      3'd3:    p = 3'd2;
      3'd4:    p = 3'd0;
      3'd5:    p = 3'd3;
      3'd6:    p = 3'd5;
      default: p = 3'd1;
    endcase
    return p;
  endfunction

  // plane order within a hires fetch unit
  function automatic logic [2:0] hires_plane(input logic [1:0] ctr);
    logic [2:0] p;
    case (ctr)
      2'd0:    p = 3'd4;
      2'd1:    p = 3'd2;
      2'd2:    p = 3'd3;
      default: p = 3'd1;
    endcase
    return p;
  endfunction

  function automatic slot_t slot_lookup(input logic [15:0] ctl, input logic last,
                                        input logic [2:0] ctr);
    slot_t      s;
    logic [2:0] bpu;
    logic [2:0] p;
    logic       m;
    bpu = ctl[CON_BPU_LSB +: 3];
    if (ctl[CON_SHRES_BIT]) begin
      if (bpu > 3'd2) bpu = 3'd0;
      p = ctr[0] ? 3'd1 : 3'd2;
      m = last && (ctr[2:1] == 2'b11);
    end else if (ctl[CON_HIRES_BIT]) begin
      if (bpu > 3'd4) bpu = 3'd0;
      p = hires_plane(ctr[1:0]);
      m = last && ctr[2];
    end else begin
      if (bpu == 3'd7) bpu = 3'd4;
      p = lores_plane(ctr);
      m = last;
    end
    if (p == 3'd0 || p > bpu) begin
      p = 3'd0;
      m = 1'b0;
    end
    s.plane      = p;
    s.add_modulo = m;
    return s;
  endfunction

  function automatic logic [2:0] res_mask(input logic [15:0] ctl);
    logic [2:0] m;
    if (ctl[CON_SHRES_BIT]) m = MASK_SHRES;
    else if (ctl[CON_HIRES_BIT]) m = MASK_HIRES;
    else m = MASK_LORES;
    return m;
  endfunction

endpackage

// ===== rtl/core/bdss_rules.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_rules
// applies one cycle's signal flags to the sequencer flip-flops under the
// original or enhanced rule set
// ----------------------------------------------------------------------------
module bdss_rules (
  input  logic           ecs_mode,
  input  bdss_pkg::in_t  item,
  input  bdss_pkg::st_t  st,
  output bdss_pkg::st_t  st_upd
);

  always_comb begin
    bdss_pkg::st_t s;
    logic dset, dclr, vset, vclr, shw, rhw, bs, bp;
    s    = st;
    dset = item.dma_set;
    dclr = item.dma_clr;
    vset = item.vflop_set;
    vclr = item.vflop_clr;
    shw  = item.hw_start;
    rhw  = item.hw_stop;
    bs   = item.ddf_start;
    bp   = item.ddf_stop;

    if (item.con_write) s.control_word = item.con_value;

    if (!ecs_mode) begin
      if (dclr && !dset) begin
        s.dma_enabled   = 1'b0;
        s.fetch_running = 1'b0;
        s.unit_counter  = 2'd0;
      end else if (dset && !dclr) begin
        s.dma_enabled = 1'b1;
      end

      if (vset && !vclr) begin
        s.vert_window_on = 1'b1;
      end else if (vclr && !vset) begin
        s.vert_window_on = 1'b0;
        s.fetch_running  = 1'b0;
        s.unit_counter   = 2'd0;
      end

      if (shw && !rhw) begin
        s.hw_window_seen = 1'b1;
      end else if (rhw && !shw) begin
        s.hw_stop_seen = s.hw_stop_seen | s.fetch_running;
        s.stop_request = s.stop_request | s.fetch_running;
      end

      if (bs && bp) begin
        if (s.fetch_running) begin
          s.fetch_started = 1'b0;
          s.fetch_stopped = 1'b1;
          s.stop_request  = 1'b1;
        end else begin
          s.fetch_started = s.fetch_started | s.hw_window_seen;
          s.fetch_running = s.hw_window_seen & s.vert_window_on & s.dma_enabled;
        end
      end else if (bs) begin
        s.fetch_started = s.fetch_started | (s.hw_window_seen & s.dma_enabled);
        s.fetch_running = (s.fetch_running | s.hw_window_seen)
                          & s.vert_window_on & s.dma_enabled;
      end else if (bp) begin
        if (s.fetch_running) s.fetch_started = 1'b0;
        s.fetch_stopped = s.fetch_stopped | s.fetch_running;
        s.stop_request  = s.stop_request | s.fetch_running;
      end

      if (item.line_done) begin
        s.hw_stop_seen = 1'b0;
        s.stop_request = 1'b0;
      end
    end else begin
      if (vset && !vclr) begin
        s.vert_window_on = 1'b1;
      end else if (vclr && !vset) begin
        s.vert_window_on = 1'b0;
        s.fetch_running  = 1'b0;
        s.unit_counter   = 2'd0;
      end

      if (shw && !rhw) begin
        s.hw_window_seen = 1'b1;
        s.fetch_running  = s.fetch_running | (s.fetch_started & !bp);
      end else if (rhw && !shw) begin
        s.hw_stop_seen = 1'b1;
        s.stop_request = s.stop_request | s.fetch_running;
      end

      // a simultaneous window start and stop masks the fetch flags
      if (!(shw && rhw)) begin
        if (bs && bp) begin
          if (!shw) begin
            s.fetch_stopped = s.fetch_stopped | s.fetch_running;
            s.stop_request  = s.stop_request | s.fetch_running;
          end
          s.fetch_started = 1'b1;
          if (!rhw) begin
            s.fetch_running = (s.fetch_running | s.hw_window_seen)
                              & s.vert_window_on & s.dma_enabled;
          end
        end else if (bs) begin
          s.fetch_started = 1'b1;
          s.fetch_running = (s.fetch_running | s.hw_window_seen)
                            & s.vert_window_on & s.dma_enabled;
        end else if (bp) begin
          s.fetch_started = 1'b0;
          s.fetch_stopped = s.fetch_stopped | s.fetch_running;
          s.stop_request  = s.stop_request | s.fetch_running;
        end
      end

      if (dclr && !dset) begin
        s.dma_enabled   = 1'b0;
        s.fetch_running = 1'b0;
        s.unit_counter  = 2'd0;
      end else if (dset && !dclr) begin
        s.dma_enabled   = 1'b1;
        s.fetch_running = (s.fetch_running | s.hw_window_seen)
                          & s.vert_window_on & s.fetch_started;
      end

      if (item.line_done) begin
        s.hw_stop_seen   = 1'b0;
        s.hw_window_seen = 1'b0;
        s.fetch_stopped  = 1'b0;
      end
    end

    st_upd = s;
  end

endmodule

// ===== rtl/core/bdss_slot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_slot
// fetch unit boundary handling, fetch slot lookup and playfield draw compare
// ----------------------------------------------------------------------------
module bdss_slot #(
  parameter int LINE_CYCLES = 227
) (
  input  logic                          ecs_mode,
  input  logic [bdss_pkg::CFG_DATA_W-1:0] scroll_odd,
  input  logic [bdss_pkg::CFG_DATA_W-1:0] scroll_even,
  input  logic [7:0]                    hpos,
  input  logic                          line_done,
  input  bdss_pkg::st_t                 st,
  output bdss_pkg::st_t                 st_next,
  output bdss_pkg::out_t                result
);

  localparam logic [7:0] LINE_POS = 8'(LINE_CYCLES);

  always_comb begin
    bdss_pkg::st_t   s;
    bdss_pkg::slot_t slot;
    logic [2:0]      ctr;
    logic [2:0]      mask;
    logic [2:0]      pos;
    s    = st;
    slot = '0;
    ctr  = {s.unit_counter, hpos[0]};
    mask = bdss_pkg::res_mask(s.control_word);
    // position zero compares as the line length
    pos  = (hpos == 8'd0) ? LINE_POS[2:0] : hpos[2:0];

    if (line_done) begin
      result = '0;
    end else begin
      // fetch unit boundary: retire the last unit, arm a pending stop
      if (ctr == 3'd0) begin
        if (s.last_unit) begin
          s.fetch_running = 1'b0;
          s.last_unit     = 1'b0;
          s.fetch_stopped = 1'b0;
          if (!ecs_mode) s.hw_window_seen = 1'b0;
        end
        if (s.stop_request) begin
          s.stop_request = 1'b0;
          s.last_unit    = 1'b1;
        end
      end

      if (s.fetch_running) begin
        slot = bdss_pkg::slot_lookup(s.control_word, s.last_unit, ctr);
        if (hpos[0]) s.unit_counter = s.unit_counter + 2'd1;
      end else begin
        s.unit_counter = 2'd0;
      end

      result.plane      = slot.plane;
      result.add_modulo = slot.add_modulo;
      result.draw_odd   = (pos & mask) == (scroll_odd[2:0] & mask);
      result.draw_even  = (pos & mask) == (scroll_even[2:0] & mask);
    end

    st_next = s;
  end

endmodule

// ===== rtl/core/bitplane_dma_slot_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitplane_dma_slot_sequencer_core
// one bitplane dma fetch slot decision per display bus cycle
// ----------------------------------------------------------------------------
// Takes one item per clock, one per display bus cycle in order, and returns
// one result item for each: the bitplane fetched in that cycle (0 for none),
// whether it is in the last fetch unit (modulo added), and the odd and even
// playfield draw flags. Throughput is one item every cycle while rsp_ready
// keeps up; items pass the input register, then the result register, which
// holds a result while it waits for rsp_ready. The sequencer flip-flops close
// their update loop through the flag rules and the slot logic, which is what
// holds the rate at one. Configuration (ecs_mode, scroll_odd, scroll_even)
// is written through the plain write port; the user must write it only while
// no item is in flight, which the block leaves unchecked; index 3 is ignored.
module bitplane_dma_slot_sequencer_core #(
  parameter int LINE_CYCLES = 227
) (
  input  logic                             clk,
  input  logic                             rst,

  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [bdss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdss_pkg::CFG_DATA_W-1:0] cfg_wr_data,

  // bus cycle items in
  input  logic                             req_valid,
  output logic                             req_ready,
  input  bdss_pkg::in_t                    req_item,

  // slot result items out
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output bdss_pkg::out_t                   rsp_item
);

  // configuration registers
  logic                             ecs_mode;
  logic [bdss_pkg::CFG_DATA_W-1:0]  scroll_odd;
  logic [bdss_pkg::CFG_DATA_W-1:0]  scroll_even;

  // input register
  logic          item_valid;
  bdss_pkg::in_t item_q;

  // sequencer state
  bdss_pkg::st_t st;
  bdss_pkg::st_t st_upd;
  bdss_pkg::st_t st_next;

  bdss_pkg::out_t result;
  logic           advance;

  // the held item moves to the result register when that register is free
  // or is emptied in this cycle
  assign advance   = item_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ecs_mode    <= 1'b0;
      scroll_odd  <= '0;
      scroll_even <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bdss_pkg::REG_ECS_MODE:    ecs_mode    <= cfg_wr_data[0];
        bdss_pkg::REG_SCROLL_ODD:  scroll_odd  <= cfg_wr_data;
        bdss_pkg::REG_SCROLL_EVEN: scroll_even <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // input register, no reset on payload
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ready) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item_q <= req_item;
    end
  end

  // signal flags first, then the slot of this cycle with the updated state
  bdss_rules u_rules (
    .ecs_mode (ecs_mode),
    .item     (item_q),
    .st       (st),
    .st_upd   (st_upd)
  );

  bdss_slot #(
    .LINE_CYCLES (LINE_CYCLES)
  ) u_slot (
    .ecs_mode    (ecs_mode),
    .scroll_odd  (scroll_odd),
    .scroll_even (scroll_even),
    .hpos        (item_q.hpos),
    .line_done   (item_q.line_done),
    .st          (st_upd),
    .st_next     (st_next),
    .result      (result)
  );

  // sequencer flip-flops advance once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_item <= result;
    end
  end

  // no modulo without a fetch
  a_mod_needs_fetch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_item.add_modulo && rsp_item.plane == 3'd0))
    else $error("add_modulo set with no plane fetched");

  // plane seven is never fetched
  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_item.plane != 3'd7)
    else $error("plane out of range");

  // a result only appears after an item left the input register
  a_rsp_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(advance))
    else $error("result without a source item");

  // end of line gives an all-zero result
  a_line_done_zero: assert property (@(posedge clk) disable iff (rst)
    advance && item_q.line_done |=>
      rsp_item.plane == 3'd0 && !rsp_item.add_modulo &&
      !rsp_item.draw_odd && !rsp_item.draw_even)
    else $error("end of line result not zero");

endmodule

// ===== tb/bdss_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_tb_pkg
// slot scoreboard for the bitplane dma slot sequencer testbench: predicts one
// slot result per accepted item and checks results in order
// ----------------------------------------------------------------------------
package bdss_tb_pkg;
  import bdss_pkg::*;

  localparam logic [7:0] LINE_LEN = 8'd227;

  // plane order per fetch unit position, entry 0 in the low bits
  localparam logic [23:0] LORES_ORDER = {3'd1, 3'd5, 3'd3, 3'd0, 3'd2, 3'd6, 3'd4, 3'd0};
  localparam logic [11:0] HIRES_ORDER = {3'd1, 3'd3, 3'd2, 3'd4};

  class bdss_slot_scoreboard;
    logic        ecs;
    logic [3:0]  scr_odd, scr_even;

    logic [15:0] ctl;
    logic        vwin, dma_on, hw_seen, hw_stop_seen;
    logic        ddf_started, ddf_stopped, running, last_u, stop_req;
    logic [1:0]  unit_ctr;

    out_t        slot_q[$];
    int          n_err, n_checked, n_fetch, n_mod;

    function new();
      ecs = 1'b0; scr_odd = '0; scr_even = '0;
      ctl = '0; vwin = 1'b0; dma_on = 1'b0; hw_seen = 1'b0; hw_stop_seen = 1'b0;
      ddf_started = 1'b0; ddf_stopped = 1'b0; running = 1'b0; last_u = 1'b0;
      stop_req = 1'b0; unit_ctr = '0;
      n_err = 0; n_checked = 0; n_fetch = 0; n_mod = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ECS_MODE:    ecs = val[0];
        REG_SCROLL_ODD:  scr_odd = val;
        REG_SCROLL_EVEN: scr_even = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return slot_q.size();
    endfunction

    // flag rules first, then the slot of this cycle from the updated state
    function void note_item(in_t it);
      out_t       r;
      logic       dset, dclr, vset, vclr, hws, hwp, bs, bp, done, m;
      logic [2:0] ctr, bpu, p, msk;
      logic [7:0] jj;
      r    = '0;
      dset = it.dma_set && !it.dma_clr;
      dclr = it.dma_clr && !it.dma_set;
      vset = it.vflop_set && !it.vflop_clr;
      vclr = it.vflop_clr && !it.vflop_set;
      hws  = it.hw_start && !it.hw_stop;
      hwp  = it.hw_stop && !it.hw_start;
      bs   = it.ddf_start;
      bp   = it.ddf_stop;
      done = it.line_done;
      if (it.con_write) ctl = it.con_value;

      if (!ecs) begin
        if (dclr) begin
          dma_on = 1'b0; running = 1'b0; unit_ctr = '0;
        end else if (dset) dma_on = 1'b1;
        if (vset) vwin = 1'b1;
        else if (vclr) begin
          vwin = 1'b0; running = 1'b0; unit_ctr = '0;
        end
        if (hws) hw_seen = 1'b1;
        else if (hwp) begin
          hw_stop_seen |= running; stop_req |= running;
        end
        if (bs && bp) begin
          if (running) begin
            ddf_started = 1'b0; ddf_stopped = 1'b1; stop_req = 1'b1;
          end else begin
            ddf_started = ddf_started || hw_seen;
            running = hw_seen && vwin && dma_on;
          end
        end else if (bs) begin
          ddf_started |= hw_seen && dma_on;
          running = (running || hw_seen) && vwin && dma_on;
        end else if (bp) begin
          if (running) ddf_started = 1'b0;
          ddf_stopped |= running;
          stop_req |= running;
        end
        if (done) begin
          hw_stop_seen = 1'b0; stop_req = 1'b0;
        end
      end else begin
        if (vset) vwin = 1'b1;
        else if (vclr) begin
          vwin = 1'b0; running = 1'b0; unit_ctr = '0;
        end
        if (hws) begin
          hw_seen = 1'b1;
          running |= ddf_started && !bp;
        end else if (hwp) begin
          hw_stop_seen = 1'b1;
          stop_req |= running;
        end
        if (!(it.hw_start && it.hw_stop)) begin
          if (bs && bp) begin
            if (!it.hw_start) begin
              ddf_stopped |= running; stop_req |= running;
            end
            ddf_started = 1'b1;
            if (!it.hw_stop) running = (running || hw_seen) && vwin && dma_on;
          end else if (bs) begin
            ddf_started = 1'b1;
            running = (running || hw_seen) && vwin && dma_on;
          end else if (bp) begin
            ddf_started = 1'b0;
            ddf_stopped |= running;
            stop_req |= running;
          end
        end
        if (dclr) begin
          dma_on = 1'b0; running = 1'b0; unit_ctr = '0;
        end else if (dset) begin
          dma_on = 1'b1;
          running = (running || hw_seen) && vwin && ddf_started;
        end
        if (done) begin
          hw_stop_seen = 1'b0; hw_seen = 1'b0; ddf_stopped = 1'b0;
        end
      end

      if (!done) begin
        ctr = {unit_ctr, it.hpos[0]};
        // fetch unit boundary: close the last unit, open a pending one
        if (ctr == 3'd0) begin
          if (last_u) begin
            running = 1'b0; last_u = 1'b0; ddf_stopped = 1'b0;
            if (!ecs) hw_seen = 1'b0;
          end
          if (stop_req) begin
            stop_req = 1'b0; last_u = 1'b1;
          end
        end
        if (running) begin
          bpu = ctl[CON_BPU_LSB +: 3];
          if (ctl[CON_SHRES_BIT]) begin
            if (bpu > 3'd2) bpu = 3'd0;
            p = ctr[0] ? 3'd1 : 3'd2;
            m = last_u && (ctr >= 3'd6);
          end else if (ctl[CON_HIRES_BIT]) begin
            if (bpu > 3'd4) bpu = 3'd0;
            p = HIRES_ORDER[ctr[1:0]*3 +: 3];
            m = last_u && (ctr >= 3'd4);
          end else begin
            if (bpu == 3'd7) bpu = 3'd4;
            p = LORES_ORDER[ctr*3 +: 3];
            m = last_u;
          end
          if (p == 3'd0 || p > bpu) begin
            p = 3'd0; m = 1'b0;
          end
          r.plane = p;
          r.add_modulo = m;
          if (it.hpos[0]) unit_ctr = unit_ctr + 2'd1;
        end else unit_ctr = '0;

        msk = ctl[CON_SHRES_BIT] ? 3'b001 : (ctl[CON_HIRES_BIT] ? 3'b011 : 3'b111);
        jj = (it.hpos != 8'd0) ? it.hpos : LINE_LEN;
        r.draw_odd  = (jj[2:0] & msk) == (scr_odd[2:0] & msk);
        r.draw_even = (jj[2:0] & msk) == (scr_even[2:0] & msk);
      end
      if (r.plane != 3'd0) n_fetch++;
      if (r.add_modulo) n_mod++;
      slot_q.push_back(r);
    endfunction

    function void check_slot(out_t got);
      out_t w;
      if (slot_q.size() == 0) begin
        $error("slot result with nothing expected: %h", got);
        n_err++;
        return;
      end
      w = slot_q.pop_front();
      n_checked++;
      if (got.plane !== w.plane) begin
        $error("plane mismatch: expected %0d, got %0d", w.plane, got.plane);
        n_err++;
      end
      if (got.add_modulo !== w.add_modulo) begin
        $error("add_modulo mismatch: expected %0d, got %0d", w.add_modulo, got.add_modulo);
        n_err++;
      end
      if (got.draw_odd !== w.draw_odd) begin
        $error("draw_odd mismatch: expected %0d, got %0d", w.draw_odd, got.draw_odd);
        n_err++;
      end
      if (got.draw_even !== w.draw_even) begin
        $error("draw_even mismatch: expected %0d, got %0d", w.draw_even, got.draw_even);
        n_err++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_bitplane_dma_slot_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitplane_dma_slot_sequencer_core
// self-checking testbench for the bitplane dma slot sequencer core
// ----------------------------------------------------------------------------
// Drives bus cycle items through the valid/ready input channel and checks
// every slot result in order against a cycle-level prediction kept by the
// slot scoreboard. A short directed run hits cycle zero, position 255, all
// resolutions with out-of-range plane counts and every set/clear pair given
// together. Random runs then feed short display lines (window and fetch
// start/stop, end of line) mixed with noise items, under both rule sets,
// extreme and random scroll values, and four idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_bitplane_dma_slot_sequencer_core;
  import bdss_pkg::*;
  import bdss_tb_pkg::*;

  // flag bit positions in the packed flag vector used to build items
  localparam logic [8:0] FL_DMA_SET   = 9'h001;
  localparam logic [8:0] FL_DMA_CLR   = 9'h002;
  localparam logic [8:0] FL_VF_SET    = 9'h004;
  localparam logic [8:0] FL_VF_CLR    = 9'h008;
  localparam logic [8:0] FL_HW_START  = 9'h010;
  localparam logic [8:0] FL_HW_STOP   = 9'h020;
  localparam logic [8:0] FL_DDF_START = 9'h040;
  localparam logic [8:0] FL_DDF_STOP  = 9'h080;
  localparam logic [8:0] FL_LINE_DONE = 9'h100;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 40;
  localparam int QUIET_LIMIT  = 1000;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req_item  = '0;

  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp_item;

  bdss_slot_scoreboard sb;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int n_sent = 0;
  int quiet = 0;

  bitplane_dma_slot_sequencer_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_item    (req_item),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_item    (rsp_item)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side backpressure, random per cycle at the current stall rate
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // both channels are sampled here, on the values present at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_item(req_item);
      if (rsp_valid && rsp_ready) sb.check_slot(rsp_item);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
    end
  end

  // watchdog: too long with no item moving on either channel
  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d results still expected",
             QUIET_LIMIT, sb.pending());
    $display("Some tests failed");
    $finish;
  end

  function automatic in_t mk_item(input logic [7:0] h, input logic [8:0] fl,
                                  input logic cw_en, input logic [15:0] cw);
    in_t it;
    it = '0;
    it.hpos      = h;
    it.con_write = cw_en;
    it.con_value = cw;
    it.dma_set   = |(fl & FL_DMA_SET);
    it.dma_clr   = |(fl & FL_DMA_CLR);
    it.vflop_set = |(fl & FL_VF_SET);
    it.vflop_clr = |(fl & FL_VF_CLR);
    it.hw_start  = |(fl & FL_HW_START);
    it.hw_stop   = |(fl & FL_HW_STOP);
    it.ddf_start = |(fl & FL_DDF_START);
    it.ddf_stop  = |(fl & FL_DDF_STOP);
    it.line_done = |(fl & FL_LINE_DONE);
    return it;
  endfunction

  // control word with a chosen resolution and a mostly sensible plane count
  function automatic logic [15:0] rand_ctl();
    logic [15:0] cw;
    int          res;
    cw  = 16'($urandom());
    res = $urandom_range(0, 2);
    cw[CON_SHRES_BIT] = (res == 2);
    cw[CON_HIRES_BIT] = (res == 1);
    if ($urandom_range(0, 99) < 80)
      cw[CON_BPU_LSB +: 3] = 3'($urandom_range(1, (res == 0) ? 6 : (res == 1) ? 4 : 2));
    return cw;
  endfunction

  task automatic send_item(input in_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    n_sent++;
  endtask

  // drop valid, let every expected result come back, then a short settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    src_idle_pct  = (mode == IDLE_SRC || mode == IDLE_BOTH) ? ((mode == IDLE_SRC) ? 63 : 9) : 0;
    snk_stall_pct = (mode == IDLE_SNK || mode == IDLE_BOTH) ? ((mode == IDLE_SNK) ? 63 : 9) : 0;
  endtask

  // one short display line: consecutive positions, window and fetch
  // start/stop at random offsets, end of line last; some flags dropped or
  // sprinkled at random so that broken lines also show up
  task automatic run_line(output int n);
    int          len, base, o_ds, o_hs, o_dp, o_hp, o_vc, o_dc, o_cw;
    logic        vs_head, ds_head, cw_head;
    logic [15:0] cw;
    logic [8:0]  fl;
    len  = $urandom_range(20, 56);
    base = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 227 - len)
                                        : $urandom_range(0, 255 - len);
    o_ds = ($urandom_range(0, 99) < 90) ? $urandom_range(0, len / 3) : -1;
    o_hs = ($urandom_range(0, 99) < 90) ? $urandom_range(0, len / 3) : -1;
    o_dp = ($urandom_range(0, 99) < 90) ? $urandom_range(len / 2, len - 10) : -1;
    o_hp = ($urandom_range(0, 99) < 90) ? $urandom_range(len / 2, len - 1) : -1;
    o_vc = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : -1;
    o_dc = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len - 1) : -1;
    o_cw = ($urandom_range(0, 99) < 5) ? $urandom_range(1, len - 1) : -1;
    vs_head = ($urandom_range(0, 99) < 30);
    ds_head = ($urandom_range(0, 99) < 40);
    cw_head = ($urandom_range(0, 99) < 30);
    for (int o = 0; o < len; o++) begin
      fl = '0;
      if (o == 0 && vs_head) fl |= FL_VF_SET;
      if (o == 0 && ds_head) fl |= FL_DMA_SET;
      if (o == o_ds) fl |= FL_DDF_START;
      if (o == o_hs) fl |= FL_HW_START;
      if (o == o_dp) fl |= FL_DDF_STOP;
      if (o == o_hp) fl |= FL_HW_STOP;
      if (o == o_vc) fl |= FL_VF_CLR;
      if (o == o_dc) fl |= FL_DMA_CLR;
      if (o == len - 1 && $urandom_range(0, 99) < 95) fl |= FL_LINE_DONE;
      if ($urandom_range(0, 99) < 3) fl |= 9'(1) << $urandom_range(0, 8);
      cw = rand_ctl();
      send_item(mk_item(8'(base + o), fl, (o == 0 && cw_head) || o == o_cw, cw));
    end
    n = len;
  endtask

  // fully random items, every field including the end-of-line flag
  task automatic noise_burst(output int n);
    logic [63:0] rnd;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      rnd = {$urandom(), $urandom()};
      send_item(rnd[$bits(in_t)-1:0]);
    end
  endtask

  initial begin
    logic [3:0] ph_ecs, ph_odd, ph_even;
    int         cnt, got;
    sb = new();
    set_idle(IDLE_NONE);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers, lores 6 planes, one full fetch run to the
    // last unit, then set/clear pairs, odd positions and out-of-range counts
    send_item(mk_item(8'd0, FL_VF_SET | FL_DMA_SET, 1'b1, 16'h6000));
    send_item(mk_item(8'd1, FL_HW_START, 1'b0, 16'h0000));
    send_item(mk_item(8'd2, FL_DDF_START, 1'b0, 16'h0000));
    for (int h = 3; h <= 10; h++) send_item(mk_item(8'(h), '0, 1'b0, 16'h0000));
    send_item(mk_item(8'd11, FL_DDF_STOP, 1'b0, 16'h0000));
    for (int h = 12; h <= 17; h++) send_item(mk_item(8'(h), '0, 1'b0, 16'h0000));
    send_item(mk_item(8'd18, FL_DMA_SET | FL_DMA_CLR | FL_VF_SET | FL_VF_CLR |
                             FL_HW_START | FL_HW_STOP, 1'b0, 16'h0000));
    send_item(mk_item(8'd255, FL_DDF_START | FL_DDF_STOP, 1'b1, 16'hFFFF));
    send_item(mk_item(8'd128, FL_DDF_START, 1'b1, 16'hD000));   // hires, 5 planes
    send_item(mk_item(8'd129, '0, 1'b1, 16'h2040));             // superhires, 2 planes
    send_item(mk_item(8'd130, '0, 1'b1, 16'h7000));             // lores, 7 planes
    send_item(mk_item(8'd131, FL_LINE_DONE, 1'b0, 16'h0000));
    send_item(mk_item(8'd0, FL_DMA_CLR | FL_VF_CLR | FL_HW_STOP | FL_DDF_STOP,
                      1'b0, 16'h0000));

    // random phases: rule set and scroll values change between phases,
    // extremes first, idle pattern cycles through all four
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      ph_ecs  = 4'($urandom_range(0, 7) * 2) | 4'((8'b0101_1010 >> ph) & 1);
      ph_odd  = (ph < 4) ? ((ph == 1 || ph == 2) ? 4'hF : 4'h0) : 4'($urandom_range(0, 15));
      ph_even = (ph < 4) ? ((ph == 1 || ph == 3) ? 4'hF : 4'h0) : 4'($urandom_range(0, 15));
      write_reg(REG_ECS_MODE, ph_ecs);
      write_reg(REG_SCROLL_ODD, ph_odd);
      write_reg(REG_SCROLL_EVEN, ph_even);
      set_idle(idle_mode_e'(ph % 4));
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) run_line(got);
        else noise_burst(got);
        cnt += got;
      end
    end

    wait_idle();
    $display("ran %0d items over %0d register settings in both rule sets, %0d results checked",
             n_sent, PHASES + 1, sb.n_checked);
    $display("predicted %0d plane fetches, %0d of them with modulo added",
             sb.n_fetch, sb.n_mod);
    if (sb.n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
